/* sv/a85sd_pkg.sv */
package a85sd_pkg;

    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_U     = 8'h75;
    localparam logic [7:0] CHAR_Z     = 8'h7A;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;

    localparam logic [31:0] W85_4 = 32'(85 * 85 * 85 * 85);
    localparam logic [31:0] W85_3 = 32'(85 * 85 * 85);
    localparam logic [31:0] W85_2 = 32'(85 * 85);
    localparam logic [31:0] W85_1 = 32'(85);
    localparam logic [31:0] W85_0 = 32'(1);

    localparam int QPTR_W = 2;
    localparam int QDEPTH = 1 << QPTR_W;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_DONE,
        TAIL_ERR
    } tail_t;

    // one request's worth of results: nbytes data bytes, msb first, then the tail
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        tail_t       tail;
    } cmd_t;

    function automatic logic [31:0] weight85(input logic [2:0] pos);
        logic [31:0] w;
        unique case (pos)
            3'd0:    w = W85_4;
            3'd1:    w = W85_3;
            3'd2:    w = W85_2;
            3'd3:    w = W85_1;
            default: w = W85_0;
        endcase
        return w;
    endfunction

    function automatic logic is_skipped(input logic [7:0] c);
        return c == 8'h00 || c == 8'h08 || c == 8'h09 || c == 8'h0A ||
               c == 8'h0C || c == 8'h0D || c == 8'h20 || c == 8'h7F;
    endfunction

endpackage

/* sv/a85sd_in_if.sv */
interface a85sd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_text;

    modport source (output valid, output in_char, output end_of_text, input ready);
    modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

/* sv/a85sd_out_if.sv */
interface a85sd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       run_last;

    modport source (output valid, output out_byte, output kind, output run_last, input ready);
    modport sink   (input valid, input out_byte, input kind, input run_last, output ready);
endinterface

/* sv/a85sd_front.sv */
module a85sd_front (
    input  logic              clk,
    input  logic              rst_n,
    a85sd_in_if.sink          chars,
    input  logic              q_full,
    output logic              q_push,
    output a85sd_pkg::cmd_t   q_cmd
);
    import a85sd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_BODY,
        PH_TILDE,
        PH_IGNORE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  dc_reg, dc_next;

    logic [7:0]  c;
    logic        accept;
    logic        is_digit;
    logic [31:0] prod;
    logic [31:0] sum;
    logic [31:0] close_sum;
    logic        fail;
    cmd_t        cmd;

    assign c           = chars.in_char;
    assign chars.ready = !q_full;
    assign accept      = chars.valid && chars.ready;
    assign is_digit    = (c >= CHAR_BANG) && (c <= CHAR_U);
    assign prod        = 32'(c - CHAR_BANG) * weight85(dc_reg);
    assign sum         = acc_reg + prod;
    assign close_sum   = acc_reg + weight85(dc_reg - 3'd1);

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        dc_next     = dc_reg;
        fail        = 1'b0;
        cmd.word    = '0;
        cmd.nbytes  = 3'd0;
        cmd.tail    = TAIL_NONE;

        unique case (phase_reg)
            PH_HDR0:
            begin
                if (c == CHAR_LT)
                    phase_next = PH_HDR1;
                else
                    fail = 1'b1;
            end
            PH_HDR1:
            begin
                if (c == CHAR_TILDE)
                    phase_next = PH_BODY;
                else
                    fail = 1'b1;
            end
            PH_BODY:
            begin
                unique if (is_digit)
                begin
                    if (dc_reg == 3'd4)
                    begin
                        cmd.word   = sum;
                        cmd.nbytes = 3'd4;
                        acc_next   = '0;
                        dc_next    = 3'd0;
                    end
                    else
                    begin
                        acc_next = sum;
                        dc_next  = dc_reg + 3'd1;
                    end
                end
                else if (c == CHAR_Z)
                begin
                    if (dc_reg != 3'd0)
                        fail = 1'b1;
                    else
                        cmd.nbytes = 3'd4;
                end
                else if (c == CHAR_TILDE)
                    phase_next = PH_TILDE;
                else
                    fail = !is_skipped(c);
            end
            PH_TILDE:
            begin
                if (c == CHAR_GT)
                begin
                    if (dc_reg != 3'd0)
                    begin
                        cmd.word   = close_sum;
                        cmd.nbytes = dc_reg - 3'd1;
                    end
                    cmd.tail   = TAIL_DONE;
                    phase_next = PH_IGNORE;
                end
                else
                    fail = 1'b1;
            end
            default: ;
        endcase

        if (fail)
        begin
            cmd.tail   = TAIL_ERR;
            phase_next = PH_IGNORE;
        end

        if (chars.end_of_text)
        begin
            if (phase_next == PH_HDR0 || phase_next == PH_HDR1 ||
                phase_next == PH_TILDE)
                cmd.tail = TAIL_ERR;
            else if (phase_next == PH_BODY)
                cmd.tail = TAIL_DONE;
            phase_next = PH_HDR0;
            acc_next   = '0;
            dc_next    = 3'd0;
        end
    end

    assign q_push = accept && (cmd.nbytes != 3'd0 || cmd.tail != TAIL_NONE);
    assign q_cmd  = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR0;
            acc_reg   <= '0;
            dc_reg    <= 3'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            dc_reg    <= dc_next;
        end
    end

endmodule

/* sv/a85sd_queue.sv */
module a85sd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  a85sd_pkg::cmd_t   push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output a85sd_pkg::cmd_t   head
);
    import a85sd_pkg::*;

    cmd_t              slots [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = count_reg == (QPTR_W + 1)'(QDEPTH);
    assign head_valid = count_reg != '0;
    assign head       = slots[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/a85sd_back.sv */
module a85sd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  a85sd_pkg::cmd_t   head,
    output logic              pop,
    a85sd_out_if.source       results
);
    import a85sd_pkg::*;

    logic        cur_valid_reg, cur_valid_next;
    cmd_t        cur_reg, cur_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    kind_t       out_kind_reg;
    logic        out_last_reg;

    logic        slot_free;
    logic        advance;
    logic [7:0]  res_byte;
    kind_t       res_kind;
    logic        res_last;

    assign slot_free = !out_valid_reg || results.ready;
    assign advance   = cur_valid_reg && slot_free;

    always_comb
    begin
        if (cur_reg.nbytes != 3'd0)
        begin
            res_byte = cur_reg.word[31:24];
            res_kind = KIND_DATA;
            res_last = (cur_reg.nbytes == 3'd1) && (cur_reg.tail == TAIL_NONE);
        end
        else
        begin
            res_byte = 8'h00;
            res_kind = (cur_reg.tail == TAIL_ERR) ? KIND_ERR : KIND_DONE;
            res_last = 1'b1;
        end
    end

    assign pop = head_valid && (!cur_valid_reg || (advance && res_last));

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        if (advance)
        begin
            cur_next.word   = {cur_reg.word[23:0], 8'h00};
            cur_next.nbytes = (cur_reg.nbytes != 3'd0) ? cur_reg.nbytes - 3'd1 : 3'd0;
            if (res_last)
                cur_valid_next = 1'b0;
        end
        if (pop)
        begin
            cur_valid_next = 1'b1;
            cur_next       = head;
        end
        out_valid_next = slot_free ? advance : out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (advance)
        begin
            out_byte_reg <= res_byte;
            out_kind_reg <= res_kind;
            out_last_reg <= res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.out_byte = out_byte_reg;
    assign results.kind     = out_kind_reg;
    assign results.run_last = out_last_reg;

endmodule

/* sv/ascii85_stream_decoder_core.sv */
// channel   dir  fields                          accepted when
// chars     in   in_char, end_of_text            chars.valid && chars.ready
// results   out  out_byte, kind, run_last        results.valid && results.ready
//
// One character a cycle is taken while the 4-entry request queue has room.
// The back end gives one result a cycle while results.ready holds. A character
// gives up to five, so digits run at one character a cycle; a 'z' gives four.
// A character's results pass the queue, current and output registers in turn.
// rst_n clears the decoder state, the queue and the output register at once.
// A stalled results port fills the queue, after which chars.ready drops.
module ascii85_stream_decoder_core (
    input  logic         clk,
    input  logic         rst_n,
    a85sd_in_if.sink     chars,
    a85sd_out_if.source  results
);
    import a85sd_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_head_valid;
    cmd_t  q_cmd;
    cmd_t  q_head;

    a85sd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_cmd)
    );

    a85sd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    a85sd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .results    (results)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("request pushed into full queue");

    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_head_valid |-> (q_head.nbytes != 3'd0 || q_head.tail != TAIL_NONE))
        else $error("queued request carries no result");

    a_head_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        q_head_valid |-> q_head.nbytes <= 3'd4)
        else $error("queued request byte count out of range");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.kind == KIND_ERR) |-> results.run_last)
        else $error("error result not last of its run");
`endif

endmodule

/* tb/testbench.sv */
module testbench;
    import a85sd_pkg::*;

    typedef enum logic [2:0] {
        WANT_LT,
        WANT_TILDE,
        IN_BODY,
        SAW_TILDE,
        SKIP_TO_END
    } text_phase_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       last;
    } result_t;

    localparam int ITEM_TARGET   = 410;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 6;

    logic clk = 1'b0;
    logic rst_n;

    a85sd_in_if  chars_if();
    a85sd_out_if results_if();

    ascii85_stream_decoder_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if)
    );

    always #1 clk = ~clk;

    logic [7:0] blank_chars [8] = '{8'h00, 8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h20, 8'h7F};

    text_phase_t text_phase   = WANT_LT;
    logic [31:0] tuple_word   = '0;
    int          tuple_digits = 0;

    result_t     decoded_due[$];
    logic [7:0]  text_buf[$];

    int  mismatch_count = 0;
    int  chars_sent     = 0;
    int  hold_request   = 0;
    bit  send_idle      = 1'b0;
    bit  recv_idle      = 1'b0;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch @%0t: %s", $time, what);
    endtask

    function automatic bit is_blank(input logic [7:0] c);
        foreach (blank_chars[i])
            if (blank_chars[i] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    // tuple kept in Horner form; padding a partial tuple of n digits is
    // (tuple + 1) * 85^(5-n)
    function automatic void decode_char(input logic [7:0] c, input logic eot);
        result_t     outs[$];
        logic [31:0] word;
        result_t     err;
        result_t     done;
        err  = '{data: 8'h00, kind: KIND_ERR, last: 1'b0};
        done = '{data: 8'h00, kind: KIND_DONE, last: 1'b0};
        case (text_phase)
            WANT_LT:
                if (c == CHAR_LT)
                    text_phase = WANT_TILDE;
                else
                begin
                    outs.insert(outs.size(), err);
                    text_phase = SKIP_TO_END;
                end
            WANT_TILDE:
                if (c == CHAR_TILDE)
                    text_phase = IN_BODY;
                else
                begin
                    outs.insert(outs.size(), err);
                    text_phase = SKIP_TO_END;
                end
            IN_BODY:
                if (c >= CHAR_BANG && c <= CHAR_U)
                begin
                    tuple_word = tuple_word * 32'd85 + 32'(c - CHAR_BANG);
                    tuple_digits++;
                    if (tuple_digits == 5)
                    begin
                        for (int i = 0; i < 4; i++)
                            outs.insert(outs.size(),
                                        result_t'{data: tuple_word[31 - 8 * i -: 8],
                                                  kind: KIND_DATA, last: 1'b0});
                        tuple_word   = '0;
                        tuple_digits = 0;
                    end
                end
                else if (c == CHAR_Z)
                begin
                    if (tuple_digits != 0)
                    begin
                        outs.insert(outs.size(), err);
                        text_phase = SKIP_TO_END;
                    end
                    else
                        repeat (4)
                            outs.insert(outs.size(),
                                        result_t'{data: 8'h00, kind: KIND_DATA, last: 1'b0});
                end
                else if (c == CHAR_TILDE)
                    text_phase = SAW_TILDE;
                else if (!is_blank(c))
                begin
                    outs.insert(outs.size(), err);
                    text_phase = SKIP_TO_END;
                end
            SAW_TILDE:
                if (c == CHAR_GT)
                begin
                    if (tuple_digits > 0)
                    begin
                        word = tuple_word + 32'd1;
                        repeat (5 - tuple_digits) word = word * 32'd85;
                        for (int i = 0; i < tuple_digits - 1; i++)
                            outs.insert(outs.size(),
                                        result_t'{data: word[31 - 8 * i -: 8],
                                                  kind: KIND_DATA, last: 1'b0});
                    end
                    outs.insert(outs.size(), done);
                    text_phase = SKIP_TO_END;
                end
                else
                begin
                    outs.insert(outs.size(), err);
                    text_phase = SKIP_TO_END;
                end
            default:
                ;
        endcase
        if (eot)
        begin
            if (text_phase == WANT_LT || text_phase == WANT_TILDE || text_phase == SAW_TILDE)
                outs.insert(outs.size(), err);
            else if (text_phase == IN_BODY)
                outs.insert(outs.size(), done);
            text_phase   = WANT_LT;
            tuple_word   = '0;
            tuple_digits = 0;
        end
        if (outs.size() > 0)
            outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i])
            decoded_due.insert(decoded_due.size(), outs[i]);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eot);
        int gap;
        gap = send_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_if.valid       <= 1'b1;
        chars_if.in_char     <= c;
        chars_if.end_of_text <= eot;
        do
            @(negedge clk);
        while (!chars_if.ready);
        @(posedge clk);
        decode_char(c, eot);
        chars_sent++;
    endtask

    task automatic send_string(input string s, input bit eot_at_end);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], eot_at_end && (i == s.len() - 1));
    endtask

    task automatic send_text_buf();
        foreach (text_buf[i])
            send_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic wait_all_results();
        chars_if.valid <= 1'b0;
        while (decoded_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] random_digit();
        case ($urandom_range(0, 3))
            0:       return CHAR_BANG;
            1:       return CHAR_U;
            default: return 8'($urandom_range(CHAR_BANG, CHAR_U));
        endcase
    endfunction

    // shapes: 0..5 well formed, 6 unclosed, 7 stray byte, 8 cut short, 9 noise only
    task automatic build_text(input int shape, input int groups);
        int         cut;
        logic [7:0] stray;
        text_buf = {};
        if (shape == 9)
        begin
            repeat ($urandom_range(1, 3))
                text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
            return;
        end
        text_buf.insert(text_buf.size(), CHAR_LT);
        text_buf.insert(text_buf.size(), CHAR_TILDE);
        repeat (groups)
        begin
            case ($urandom_range(0, 5))
                0:       text_buf.insert(text_buf.size(), CHAR_Z);
                1:       text_buf.insert(text_buf.size(), blank_chars[$urandom_range(0, 7)]);
                default: repeat (5) text_buf.insert(text_buf.size(), random_digit());
            endcase
        end
        if ($urandom_range(0, 1))
            repeat ($urandom_range(1, 4)) text_buf.insert(text_buf.size(), random_digit());
        if (shape != 6)
        begin
            text_buf.insert(text_buf.size(), CHAR_TILDE);
            text_buf.insert(text_buf.size(), CHAR_GT);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2))
                    text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
        end
        if (shape == 7)
        begin
            case ($urandom_range(0, 2))
                0:       stray = CHAR_Z;
                1:       stray = CHAR_TILDE;
                default: stray = 8'($urandom_range(0, 255));
            endcase
            text_buf.insert($urandom_range(0, text_buf.size() - 1), stray);
        end
        if (shape == 8)
        begin
            cut = $urandom_range(1, text_buf.size() - 1);
            while (text_buf.size() > cut)
                void'(text_buf.pop_back());
        end
    endtask

    task automatic test_clean_texts();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        send_string("<~z\tuuuuu!!~>Q", 1'b1);
        send_string("<~u~>", 1'b1);
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_string("<~!!!!!~>", 1'b1);
    endtask

    task automatic test_header_errors();
        send_string("x", 1'b1);
        send_string("<", 1'b1);
        send_string("<y", 1'b1);
        send_string("<~", 1'b1);
    endtask

    task automatic test_body_errors();
        send_string("<~!z!", 1'b1);
        send_string("<~~a", 1'b1);
        send_string("<~~", 1'b1);
        send_string("<~", 1'b0);
        send_char(8'hFF, 1'b1);
        send_string("<~uu", 1'b1);
    endtask

    // output held off long enough for the request queue to fill and stall input
    task automatic test_stalled_output();
        wait_all_results();
        send_idle    = 1'b0;
        recv_idle    = 1'b0;
        hold_request = LONG_HOLD;
        send_string("<~zzzzzzzzzzzz~>", 1'b1);
        wait_all_results();
    endtask

    task automatic test_random_texts();
        int mode;
        while (chars_sent < ITEM_TARGET)
        begin
            mode      = $urandom_range(0, 3);
            send_idle = mode[0];
            recv_idle = mode[1];
            build_text($urandom_range(0, 9), $urandom_range(0, 4));
            send_text_buf();
            if ($urandom_range(0, 7) == 0)
                wait_all_results();
        end
    endtask

    initial
    begin : result_checker
        int      stall_left;
        result_t want;
        stall_left = 0;
        results_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (results_if.valid && results_if.ready)
            begin
                if (decoded_due.size() == 0)
                    report_mismatch($sformatf("unexpected result byte %02h kind %0d",
                                              results_if.out_byte, results_if.kind));
                else
                begin
                    want = decoded_due.pop_front();
                    if (results_if.out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  results_if.out_byte, want.data));
                    if (results_if.kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d",
                                                  results_if.kind, want.kind));
                    if (results_if.run_last !== want.last)
                        report_mismatch($sformatf("run_last %0b, want %0b",
                                                  results_if.run_last, want.last));
                end
                stall_left = recv_idle ? $urandom_range(0, 15) : 0;
            end
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                results_if.ready <= 1'b0;
                stall_left--;
            end
            else
                results_if.ready <= 1'b1;
        end
    end

    initial
    begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        chars_if.valid       = 1'b0;
        chars_if.in_char     = 8'h00;
        chars_if.end_of_text = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_clean_texts();
        test_header_errors();
        test_body_errors();
        test_stalled_output();
        test_random_texts();
        wait_all_results();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
sv/a85sd_pkg.sv
sv/a85sd_in_if.sv
sv/a85sd_out_if.sv
sv/a85sd_front.sv
sv/a85sd_queue.sv
sv/a85sd_back.sv
sv/ascii85_stream_decoder_core.sv
tb/testbench.sv
